@@ sv/rlh_pkg.sv @@
// shared types, constants and arithmetic helpers for the rgb luma histogram
package rlh_pkg;

   localparam int CountBits = 18;
   localparam int OutBits   = 18;
   localparam int AddrBits  = 8;
   localparam int NumBins   = 1 << AddrBits;
   localparam int CompBits  = 8;
   localparam int WsumBits  = 18;
   localparam int RecipBits = 19;
   localparam int RecipShift = 28;
   localparam int ProdBits  = WsumBits + RecipBits;
   localparam int WideBits  = (CountBits > OutBits) ? CountBits : OutBits;

   localparam int LumaWr = 299;
   localparam int LumaWg = 587;
   localparam int LumaWb = 114;
   // ceil(2^28 / 1000): exact floor division for every weighted sum up to 255000
   localparam int RecipMul = ((1 << RecipShift) + 999) / 1000;

   typedef logic [CountBits-1:0] count_type;
   typedef logic [OutBits-1:0]   out_type;
   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [CompBits-1:0]  comp_type;
   typedef logic [WsumBits-1:0]  wsum_type;

   localparam count_type CountMax = '1;

   typedef enum logic [1:0] {
      CmdClear = 2'd0,
      CmdAdd   = 2'd1,
      CmdRead  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic advance;
      logic b_add;
      logic b_clear;
   } lane_ctl_type;

   function automatic wsum_type luma_wsum(comp_type r, comp_type g, comp_type b);
      wsum_type pr;
      wsum_type pg;
      wsum_type pb;
      pr = WsumBits'(r) * WsumBits'(LumaWr);
      pg = WsumBits'(g) * WsumBits'(LumaWg);
      pb = WsumBits'(b) * WsumBits'(LumaWb);
      return pr + pg + pb;
   endfunction

   function automatic addr_type luma_index(wsum_type s);
      logic [ProdBits-1:0] p;
      p = ProdBits'(s) * ProdBits'(RecipMul);
      return p[RecipShift +: AddrBits];
   endfunction

   function automatic out_type to_out(count_type c);
      logic [WideBits-1:0] w;
      w = WideBits'(c);
      return w[OutBits-1:0];
   endfunction

endpackage

@@ sv/rlh_bin_ram.sv @@
// one 256-bin count memory with per-entry valid bits and a registered read port
module rlh_bin_ram
   import rlh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      clear,
   input  logic      rd_en,
   input  addr_type  rd_addr,
   output count_type rd_data,
   input  logic      wr_en,
   input  addr_type  wr_addr,
   input  count_type wr_data
);

   count_type          mem [NumBins];
   logic [NumBins-1:0] valid_ff;
   count_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // entries never written since the last clear read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rlh_lane.sv @@
// one histogram: bin memory, write-back forwarding and saturating increment
module rlh_lane
   import rlh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  addr_type     rd_addr,
   output count_type    cur_count,
   output count_type    new_count
);

   addr_type  addr_ff;
   count_type rd_data;
   logic      fwd_add_ff;
   logic      fwd_clear_ff;
   addr_type  fwd_addr_ff;
   count_type fwd_data_ff;
   logic      fwd_hit;

   rlh_bin_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (ctl.advance & ctl.b_clear),
      .rd_en   (ctl.advance),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (ctl.advance & ctl.b_add),
      .wr_addr (addr_ff),
      .wr_data (new_count)
   );

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         addr_ff     <= rd_addr;
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_add_ff   <= 1'b0;
         fwd_clear_ff <= 1'b0;
      end else if (ctl.advance) begin
         fwd_add_ff   <= ctl.b_add;
         fwd_clear_ff <= ctl.b_clear;
      end
   end

   // the read was taken on the same edge the previous item committed
   assign fwd_hit = fwd_add_ff && (fwd_addr_ff == addr_ff);

   always_comb begin
      if (fwd_clear_ff) begin
         cur_count = '0;
      end else if (fwd_hit) begin
         cur_count = fwd_data_ff;
      end else begin
         cur_count = rd_data;
      end
   end

   assign new_count = (cur_count == CountMax) ? cur_count : cur_count + 1'b1;

endmodule

@@ sv/rgb_luma_histogram_top.sv @@
// top level of the rgb and luma histogram block
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   command, red, green, blue, bin_index
//  rsp      out  rsp_valid/rsp_stall   luma, red, green, blue and peak counts
//
// one item per cycle unless a result is held under rsp_stall: a pixel weighted
// sum is registered at acceptance in stage a, the bins are read into stage b and
// written back as the item leaves it, so each bin ram sees at most one read and
// one write per cycle. reset clears the bin valid bits directly, no sweep. a
// held result under rsp_stall freezes the whole pipeline.
module rgb_luma_histogram_top
   import rlh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  logic [7:0]    req_red,
   input  logic [7:0]    req_green,
   input  logic [7:0]    req_blue,
   input  logic [7:0]    req_bin_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [17:0]   rsp_luma_count,
   output logic [17:0]   rsp_red_count,
   output logic [17:0]   rsp_green_count,
   output logic [17:0]   rsp_blue_count,
   output logic [17:0]   rsp_peak_count
);

   logic         advance;
   logic         a_valid_ff;
   cmd_type      a_cmd_ff;
   comp_type     a_red_ff;
   comp_type     a_green_ff;
   comp_type     a_blue_ff;
   addr_type     a_index_ff;
   wsum_type     a_wsum_ff;
   logic         a_read;
   addr_type     luma_addr;
   addr_type     red_addr;
   addr_type     green_addr;
   addr_type     blue_addr;
   logic         b_valid_ff;
   cmd_type      b_cmd_ff;
   logic         b_read;
   lane_ctl_type ctl;
   count_type    luma_cur;
   count_type    luma_new;
   count_type    red_cur;
   count_type    red_new;
   count_type    green_cur;
   count_type    green_new;
   count_type    blue_cur;
   count_type    blue_new;
   count_type    peak_ff;
   count_type    peak_in;
   count_type    max_lo;
   count_type    max_hi;
   logic         rsp_valid_ff;
   out_type      rsp_luma_ff;
   out_type      rsp_red_ff;
   out_type      rsp_green_ff;
   out_type      rsp_blue_ff;
   out_type      rsp_peak_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage a: capture the item and the luma weighted sum
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_cmd_ff   <= cmd_type'(req_command);
         a_red_ff   <= req_red;
         a_green_ff <= req_green;
         a_blue_ff  <= req_blue;
         a_index_ff <= req_bin_index;
         a_wsum_ff  <= luma_wsum(req_red, req_green, req_blue);
      end
   end

   assign a_read     = (a_cmd_ff == CmdRead);
   assign luma_addr  = a_read ? a_index_ff : luma_index(a_wsum_ff);
   assign red_addr   = a_read ? a_index_ff : a_red_ff;
   assign green_addr = a_read ? a_index_ff : a_green_ff;
   assign blue_addr  = a_read ? a_index_ff : a_blue_ff;

   // stage b: bin data is out of the rams, commit happens on the next advance
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_cmd_ff <= a_cmd_ff;
      end
   end

   always_comb begin
      ctl.advance = advance;
      ctl.b_add   = 1'b0;
      ctl.b_clear = 1'b0;
      b_read      = 1'b0;
      case (b_cmd_ff)
         CmdClear: ctl.b_clear = b_valid_ff;
         CmdAdd:   ctl.b_add   = b_valid_ff;
         CmdRead:  b_read      = b_valid_ff;
         default: begin
         end
      endcase
   end

   rlh_lane u_luma (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (luma_addr),
      .cur_count (luma_cur),
      .new_count (luma_new)
   );

   rlh_lane u_red (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (red_addr),
      .cur_count (red_cur),
      .new_count (red_new)
   );

   rlh_lane u_green (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (green_addr),
      .cur_count (green_cur),
      .new_count (green_new)
   );

   rlh_lane u_blue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (blue_addr),
      .cur_count (blue_cur),
      .new_count (blue_new)
   );

   // running peak over the four incremented bins
   always_comb begin
      max_lo  = (luma_new > red_new) ? luma_new : red_new;
      max_hi  = (green_new > blue_new) ? green_new : blue_new;
      if (max_hi > max_lo) begin
         max_lo = max_hi;
      end
      peak_in = (max_lo > peak_ff) ? max_lo : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (advance) begin
         if (ctl.b_clear) begin
            peak_ff <= '0;
         end else if (ctl.b_add) begin
            peak_ff <= peak_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_read;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && b_read) begin
         rsp_luma_ff  <= to_out(luma_cur);
         rsp_red_ff   <= to_out(red_cur);
         rsp_green_ff <= to_out(green_cur);
         rsp_blue_ff  <= to_out(blue_cur);
         rsp_peak_ff  <= to_out(peak_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_luma_count  = rsp_luma_ff;
   assign rsp_red_count   = rsp_red_ff;
   assign rsp_green_count = rsp_green_ff;
   assign rsp_blue_count  = rsp_blue_ff;
   assign rsp_peak_count  = rsp_peak_ff;

endmodule

@@ sv/rlh_checker.sv @@
// port-level assertions for the rgb luma histogram, bound to the top level
module rlh_checker
   import rlh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [17:0] rsp_luma_count,
   input logic [17:0] rsp_red_count,
   input logic [17:0] rsp_green_count,
   input logic [17:0] rsp_blue_count,
   input logic [17:0] rsp_peak_count
);

   // a waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // an accepted read yields a result when rsp_stall stays low behind it
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CmdRead) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("read item produced no result");

   // no bin count exceeds the peak
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_luma_count <= rsp_peak_count && rsp_red_count <= rsp_peak_count
                 && rsp_green_count <= rsp_peak_count && rsp_blue_count <= rsp_peak_count)
      else $error("bin count above peak");

endmodule

bind rgb_luma_histogram_top rlh_checker u_rlh_checker (.*);

@@ tb/sv/rgb_luma_histogram_top_tb.sv @@
// self-checking testbench for the rgb and luma histogram block
module rgb_luma_histogram_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rlh_pkg::*;

   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int IdleLimit      = 2000;
   localparam int DrainCycles    = 10;
   localparam int RandomPerPhase = 180;
   localparam int MaxReports     = 10;
   localparam int BuildupAdds    = 40;

   typedef struct {
      addr_type bin;
      out_type  luma;
      out_type  red;
      out_type  green;
      out_type  blue;
      out_type  peak;
   } bin_readout_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [1:0]   req_command = CmdClear;
   logic [7:0]   req_red = '0;
   logic [7:0]   req_green = '0;
   logic [7:0]   req_blue = '0;
   logic [7:0]   req_bin_index = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [17:0]  rsp_luma_count;
   logic [17:0]  rsp_red_count;
   logic [17:0]  rsp_green_count;
   logic [17:0]  rsp_blue_count;
   logic [17:0]  rsp_peak_count;

   // shadow histograms, updated as items are accepted
   count_type       luma_hist[NumBins];
   count_type       red_hist[NumBins];
   count_type       green_hist[NumBins];
   count_type       blue_hist[NumBins];
   count_type       peak_level;
   bin_readout_type pending_bin_reads[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;
   int fails         = 0;
   int n_adds        = 0;
   int n_reads       = 0;
   int n_clears      = 0;
   int n_ignored     = 0;

   rgb_luma_histogram_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_bin_index   (req_bin_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_luma_count  (rsp_luma_count),
      .rsp_red_count   (rsp_red_count),
      .rsp_green_count (rsp_green_count),
      .rsp_blue_count  (rsp_blue_count),
      .rsp_peak_count  (rsp_peak_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic comp_type luma_of(comp_type r, comp_type g, comp_type b);
      int unsigned wsum;
      int unsigned y;
      wsum = LumaWr * r + LumaWg * g + LumaWb * b;
      y = wsum / 1000;
      if (y > 255) y = 255;
      return comp_type'(y);
   endfunction

   function automatic count_type bumped(count_type v);
      return (v == CountMax) ? v : v + 1'b1;
   endfunction

   function automatic void raise_peak(count_type v);
      if (v > peak_level) peak_level = v;
   endfunction

   function automatic void clear_hist();
      foreach (luma_hist[i]) begin
         luma_hist[i]  = '0;
         red_hist[i]   = '0;
         green_hist[i] = '0;
         blue_hist[i]  = '0;
      end
      peak_level = '0;
   endfunction

   function automatic void apply_command(logic [1:0] cmd, comp_type r, comp_type g,
                                         comp_type b, addr_type idx);
      bin_readout_type rd;
      comp_type        y;
      case (cmd)
         CmdClear: begin
            clear_hist();
            n_clears++;
         end
         CmdAdd: begin
            y = luma_of(r, g, b);
            red_hist[r]   = bumped(red_hist[r]);
            raise_peak(red_hist[r]);
            green_hist[g] = bumped(green_hist[g]);
            raise_peak(green_hist[g]);
            blue_hist[b]  = bumped(blue_hist[b]);
            raise_peak(blue_hist[b]);
            luma_hist[y]  = bumped(luma_hist[y]);
            raise_peak(luma_hist[y]);
            n_adds++;
         end
         CmdRead: begin
            rd.bin   = idx;
            rd.luma  = out_type'(luma_hist[idx]);
            rd.red   = out_type'(red_hist[idx]);
            rd.green = out_type'(green_hist[idx]);
            rd.blue  = out_type'(blue_hist[idx]);
            rd.peak  = out_type'(peak_level);
            pending_bin_reads.push_back(rd);
            n_reads++;
         end
         default: n_ignored++;
      endcase
   endfunction

   initial clear_hist();

   // track accepted items first so a same-edge result finds its expectation
   always @(posedge clock) begin : monitor
      bin_readout_type want;
      logic            took;
      if (!reset) begin
         took = 1'b0;
         if (req_valid && !req_stall) begin
            took = 1'b1;
            apply_command(req_command, req_red, req_green, req_blue, req_bin_index);
         end
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            if (pending_bin_reads.size() == 0) begin
               fails++;
               if (fails <= MaxReports)
                  $display("unexpected result: luma %0d red %0d green %0d blue %0d peak %0d",
                           rsp_luma_count, rsp_red_count, rsp_green_count,
                           rsp_blue_count, rsp_peak_count);
            end else begin
               want = pending_bin_reads.pop_front();
               if (rsp_luma_count !== want.luma || rsp_red_count !== want.red ||
                   rsp_green_count !== want.green || rsp_blue_count !== want.blue ||
                   rsp_peak_count !== want.peak) begin
                  fails++;
                  if (fails <= MaxReports) begin
                     $display("bin %0d expected luma %0d red %0d green %0d blue %0d peak %0d",
                              want.bin, want.luma, want.red, want.green, want.blue,
                              want.peak);
                     $display("       got      luma %0d red %0d green %0d blue %0d peak %0d",
                              rsp_luma_count, rsp_red_count, rsp_green_count,
                              rsp_blue_count, rsp_peak_count);
                  end
               end
            end
         end
         if (took) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("no item moved for %0d cycles", IdleLimit);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] cmd, input comp_type r, input comp_type g,
                            input comp_type b, input addr_type idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_red       <= r;
      req_green     <= g;
      req_blue      <= b;
      req_bin_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sample at falling edges so the count of outstanding reads is settled
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_bin_reads.size() != 0);
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd0);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd255);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd128);
      wait_for_results();
   endtask

   task automatic test_pixel_extremes();
      send_item(CmdAdd, 8'd0, 8'd0, 8'd0, rand_byte());
      send_item(CmdAdd, 8'd255, 8'd255, 8'd255, rand_byte());
      send_item(CmdAdd, 8'd255, 8'd0, 8'd0, rand_byte());
      send_item(CmdAdd, 8'd0, 8'd255, 8'd0, rand_byte());
      send_item(CmdAdd, 8'd0, 8'd0, 8'd255, rand_byte());
      send_item(CmdAdd, 8'd1, 8'd1, 8'd1, rand_byte());
      // luma just below full scale
      send_item(CmdAdd, 8'd255, 8'd255, 8'd254, rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd0);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd255);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd76);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd149);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd29);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd1);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd254);
      wait_for_results();
   endtask

   task automatic test_repeat_and_ignore();
      // back-to-back hits on the same bins, read right behind them
      repeat (3) send_item(CmdAdd, 8'd10, 8'd20, 8'd30, rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd10);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd18);
      send_item(CmdUnused, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd20);
      send_item(CmdClear, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd10);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd30);
      wait_for_results();
   endtask

   task automatic test_bin_buildup();
      send_item(CmdClear, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      repeat (BuildupAdds) send_item(CmdAdd, 8'd77, 8'd77, 8'd77, rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd77);
      send_item(CmdAdd, 8'd77, 8'd77, 8'd77, rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd77);
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd0);
      send_item(CmdClear, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      send_item(CmdRead, rand_byte(), rand_byte(), rand_byte(), 8'd77);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_pct_in,
                                    input bit pause_midway);
      int         sent;
      int         pick;
      bit         paused;
      logic [1:0] cmd;
      comp_type   r;
      comp_type   g;
      comp_type   b;
      addr_type   idx;
      send_idle_pct = send_pct;
      stall_pct     = stall_pct_in;
      sent   = 0;
      paused = 1'b0;
      r = rand_byte();
      g = rand_byte();
      b = rand_byte();
      while (sent < RandomPerPhase) begin
         pick = $urandom_range(99);
         if (pick < 2) cmd = CmdClear;
         else if (pick < 6) cmd = CmdUnused;
         else if (pick < 70) cmd = CmdAdd;
         else cmd = CmdRead;
         // repeated pixels keep hitting the same bins
         if ($urandom_range(99) >= 40) begin
            r = rand_byte();
            g = rand_byte();
            b = rand_byte();
         end
         case ($urandom_range(7))
            0: idx = r;
            1: idx = g;
            2: idx = b;
            3: idx = luma_of(r, g, b);
            default: idx = rand_byte();
         endcase
         send_item(cmd, r, g, b, idx);
         if (cmd != CmdUnused) sent++;
         if (pause_midway && !paused && sent >= RandomPerPhase / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_pixel_extremes();
      test_repeat_and_ignore();
      test_bin_buildup();
      test_random_phase(0, 0, 1'b1);
      test_random_phase(60, 0, 1'b0);
      test_random_phase(0, 60, 1'b0);
      test_random_phase(13, 13, 1'b0);
      stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);
      fails += pending_bin_reads.size();
      $display("covered %0d pixel adds, %0d bin reads, %0d clears, %0d ignored commands",
               n_adds, n_reads, n_clears, n_ignored);
      $display("with repeated bins and sender/receiver idling at 0, 13 and 60 percent");
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/rlh_pkg.sv
sv/rlh_bin_ram.sv
sv/rlh_lane.sv
sv/rgb_luma_histogram_top.sv
sv/rlh_checker.sv
tb/sv/rgb_luma_histogram_top_tb.sv
